// File: rtl/core/clle_pkg.sv
package clle_pkg;

    localparam int NODE_SLOTS = 1024;
    localparam int ADDR_W     = $clog2(NODE_SLOTS);
    localparam int CMD_W      = 2;
    localparam int POS_W      = 10;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;
    localparam int LEN_W      = 10;
    localparam int IN_W       = 48;
    localparam int OUT_W      = 48;

    localparam logic [ADDR_W-1:0] FREE_HEAD = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] LIST_HEAD = ADDR_W'(NODE_SLOTS - 1);
    localparam logic [ADDR_W-1:0] LAST_FREE = ADDR_W'(NODE_SLOTS - 2);
    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(NODE_SLOTS - 2);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

endpackage

// File: rtl/core/clle_ram.sv
module clle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/cursor_linked_list_engine_unit.sv
// Ordered list of 32-bit values kept in a store of 1024 nodes, with slot 0 heading the free
// chain and the last slot heading the list, so up to 1022 elements fit. Each word carries a
// command (insert, delete, read) at a 1-based position and gives exactly one result word with
// status, read value and the list length after the command. Commands are handled one at a
// time. An insert into a full store, a bad position or an unknown command ends without a
// walk, and a result waits while the previous result still sits unaccepted in the output
// register. The walk to the position follows one next link per cycle through the single-port
// link memory. After reset a clearing pass over all 1024 slots builds the free chain in the
// link memory, and no word is taken until it ends. A finished result waits in the output
// register while the next command is taken.
module cursor_linked_list_engine_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // command[1:0], position[11:2], value[43:12], zero pad
    input  logic [clle_pkg::IN_W-1:0]    i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // status[1:0], read_value[33:2], list_length[43:34], zero pad
    output logic [clle_pkg::OUT_W-1:0]   o_m_tdata
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_INS_J    = 4'd3;
    localparam logic [3:0] S_INS_NJ   = 4'd4;
    localparam logic [3:0] S_WALK     = 4'd5;
    localparam logic [3:0] S_INS_LINK = 4'd6;
    localparam logic [3:0] S_INS_HOOK = 4'd7;
    localparam logic [3:0] S_DEL_V    = 4'd8;
    localparam logic [3:0] S_DEL_LV   = 4'd9;
    localparam logic [3:0] S_DEL_F    = 4'd10;
    localparam logic [3:0] S_DEL_FQ   = 4'd11;
    localparam logic [3:0] S_DEL_FH   = 4'd12;
    localparam logic [3:0] S_RD_N     = 4'd13;
    localparam logic [3:0] S_RD_V     = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0]                     r_state, n_state;
    logic [clle_pkg::ADDR_W-1:0]    r_clr, n_clr;
    logic [clle_pkg::CMD_W-1:0]     r_cmd, n_cmd;
    logic [clle_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [clle_pkg::VAL_W-1:0]     r_val, n_val;
    logic [clle_pkg::ADDR_W-1:0]    r_k, n_k;
    logic [clle_pkg::ADDR_W-1:0]    r_j, n_j;
    logic [clle_pkg::POS_W-1:0]     r_a, n_a;
    logic                           r_first, n_first;
    logic [clle_pkg::LEN_W-1:0]     r_count, n_count;
    logic [clle_pkg::STAT_W-1:0]    r_status, n_status;
    logic [clle_pkg::VAL_W-1:0]     r_rd, n_rd;
    logic                           r_ovalid, n_ovalid;
    logic [clle_pkg::STAT_W-1:0]    r_o_status, n_o_status;
    logic [clle_pkg::VAL_W-1:0]     r_o_rd, n_o_rd;
    logic [clle_pkg::LEN_W-1:0]     r_o_len, n_o_len;

    logic                           w_link_we;
    logic [clle_pkg::ADDR_W-1:0]    w_link_addr;
    logic [clle_pkg::ADDR_W-1:0]    w_link_wdata;
    logic [clle_pkg::ADDR_W-1:0]    w_link_q;
    logic                           w_val_we;
    logic [clle_pkg::ADDR_W-1:0]    w_val_addr;
    logic [clle_pkg::VAL_W-1:0]     w_val_q;

    logic                           w_accept;
    logic [clle_pkg::ADDR_W-1:0]    w_kcur;
    logic [clle_pkg::LEN_W:0]       w_ins_lim;
    logic                           w_pos_ok;

    clle_ram #(
        .WIDTH (clle_pkg::ADDR_W),
        .DEPTH (clle_pkg::NODE_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_addr  (w_link_addr),
        .i_wdata (w_link_wdata),
        .o_rdata (w_link_q)
    );

    clle_ram #(
        .WIDTH (clle_pkg::VAL_W),
        .DEPTH (clle_pkg::NODE_SLOTS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_addr  (w_val_addr),
        .i_wdata (r_val),
        .o_rdata (w_val_q)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_kcur     = r_first ? r_k : w_link_q;
    assign w_ins_lim  = {1'b0, r_count} + (clle_pkg::LEN_W + 1)'(1);

    always_comb begin
        w_pos_ok = 1'b0;
        case (r_cmd)
            clle_pkg::CMD_INSERT: begin
                w_pos_ok = (r_pos != '0) && ({1'b0, r_pos} <= w_ins_lim);
            end
            clle_pkg::CMD_DELETE, clle_pkg::CMD_READ: begin
                w_pos_ok = (r_pos != '0) && (r_pos <= r_count);
            end
            default: begin
                w_pos_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cmd      = r_cmd;
        n_pos      = r_pos;
        n_val      = r_val;
        n_k        = r_k;
        n_j        = r_j;
        n_a        = r_a;
        n_first    = r_first;
        n_count    = r_count;
        n_status   = r_status;
        n_rd       = r_rd;
        n_ovalid   = r_ovalid;
        n_o_status = r_o_status;
        n_o_rd     = r_o_rd;
        n_o_len    = r_o_len;

        w_link_we    = 1'b0;
        w_link_addr  = clle_pkg::FREE_HEAD;
        w_link_wdata = '0;
        w_val_we     = 1'b0;
        w_val_addr   = r_j;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_link_we    = 1'b1;
                w_link_addr  = r_clr;
                w_link_wdata = (r_clr < clle_pkg::LAST_FREE) ?
                               clle_pkg::ADDR_W'(r_clr + 1'b1) : '0;
                n_clr        = clle_pkg::ADDR_W'(r_clr + 1'b1);
                if (r_clr == clle_pkg::LIST_HEAD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = i_s_tdata[1:0];
                    n_pos   = i_s_tdata[11:2];
                    n_val   = i_s_tdata[43:12];
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = clle_pkg::ST_BAD_POS;
                n_rd     = '0;
                n_k      = clle_pkg::LIST_HEAD;
                n_a      = clle_pkg::POS_W'(1);
                n_first  = 1'b1;
                if (!w_pos_ok) begin
                    n_state = S_DONE;
                end else if (r_cmd == clle_pkg::CMD_INSERT) begin
                    w_link_addr = clle_pkg::FREE_HEAD;
                    n_state     = S_INS_J;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_INS_J: begin
                if (w_link_q == '0) begin
                    n_status = clle_pkg::ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_j         = w_link_q;
                    w_link_addr = w_link_q;
                    w_val_we    = 1'b1;
                    w_val_addr  = w_link_q;
                    n_state     = S_INS_NJ;
                end
            end
            S_INS_NJ: begin
                w_link_we    = 1'b1;
                w_link_addr  = clle_pkg::FREE_HEAD;
                w_link_wdata = w_link_q;
                n_state      = S_WALK;
            end
            S_WALK: begin
                w_link_addr = w_kcur;
                n_first     = 1'b0;
                if (r_a < r_pos) begin
                    n_a = r_a + 1'b1;
                end else begin
                    n_k = w_kcur;
                    case (r_cmd)
                        clle_pkg::CMD_INSERT: n_state = S_INS_LINK;
                        clle_pkg::CMD_DELETE: n_state = S_DEL_V;
                        default:              n_state = S_RD_N;
                    endcase
                end
            end
            S_INS_LINK: begin
                w_link_we    = 1'b1;
                w_link_addr  = r_j;
                w_link_wdata = w_link_q;
                n_state      = S_INS_HOOK;
            end
            S_INS_HOOK: begin
                w_link_we    = 1'b1;
                w_link_addr  = r_k;
                w_link_wdata = r_j;
                n_count      = r_count + 1'b1;
                n_status     = clle_pkg::ST_OK;
                n_state      = S_DONE;
            end
            S_DEL_V: begin
                if (w_link_q == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_j         = w_link_q;
                    w_link_addr = w_link_q;
                    n_state     = S_DEL_LV;
                end
            end
            S_DEL_LV: begin
                w_link_we    = 1'b1;
                w_link_addr  = r_k;
                w_link_wdata = w_link_q;
                n_state      = S_DEL_F;
            end
            S_DEL_F: begin
                w_link_addr = clle_pkg::FREE_HEAD;
                n_state     = S_DEL_FQ;
            end
            S_DEL_FQ: begin
                w_link_we    = 1'b1;
                w_link_addr  = r_j;
                w_link_wdata = w_link_q;
                n_state      = S_DEL_FH;
            end
            S_DEL_FH: begin
                w_link_we    = 1'b1;
                w_link_addr  = clle_pkg::FREE_HEAD;
                w_link_wdata = r_j;
                n_count      = r_count - 1'b1;
                n_status     = clle_pkg::ST_OK;
                n_state      = S_DONE;
            end
            S_RD_N: begin
                if (w_link_q == '0) begin
                    n_state = S_DONE;
                end else begin
                    w_val_addr = w_link_q;
                    n_state    = S_RD_V;
                end
            end
            S_RD_V: begin
                n_rd     = w_val_q;
                n_status = clle_pkg::ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_rd     = r_rd;
                    n_o_len    = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_first  <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_k        <= n_k;
        r_j        <= n_j;
        r_a        <= n_a;
        r_status   <= n_status;
        r_rd       <= n_rd;
        r_o_status <= n_o_status;
        r_o_rd     <= n_o_rd;
        r_o_len    <= n_o_len;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0, r_o_len, r_o_rd, r_o_status};

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= clle_pkg::MAX_LEN)
        else $error("list length beyond store capacity");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_DECODE)
        else $error("accepted word not decoded");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INS_HOOK |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the list");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> r_a <= r_pos)
        else $error("walk passed the position");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_status != clle_pkg::ST_OK) |-> r_o_rd == '0)
        else $error("failed command carries a read value");

endmodule
